FILE: sv/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared constants, command and status codes, and payload and table types.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int SLOT_COUNT     = 4;
  localparam int MAX_FRAGMENTS  = 16;
  localparam int FRAGMENT_BYTES = 192;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MASK_W = MAX_FRAGMENTS;

  localparam logic [4:0]  MAX_FRAG_C   = 5'(MAX_FRAGMENTS);
  localparam logic [7:0]  FRAG_BYTES_C = 8'(FRAGMENT_BYTES);
  localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_ABSORB  = 2'd0,
    CMD_PRUNE   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_INCOMPLETE = 2'd0,
    STAT_COMPLETE   = 2'd1,
    STAT_ERROR      = 2'd2,
    STAT_DONE       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_PRUNE
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [47:0] source_mac;
    logic [15:0] message_id;
    logic [4:0]  fragment_count;
    logic [4:0]  fragment_number;
    logic [7:0]  payload_length;
    logic [7:0]  message_type;
    logic [31:0] time_now_ms;
    logic [3:0]  release_slot;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_used;
    logic        store_payload;
    logic [11:0] write_offset;
    logic [11:0] assembled_length;
    logic [7:0]  stored_type;
    logic [47:0] stored_mac;
    logic [15:0] stored_message_id;
  } result_t;

  typedef struct packed {
    logic [47:0]       mac;
    logic [15:0]       message_id;
    logic [4:0]        frag_total;
    logic [7:0]        msg_type;
    logic [31:0]       start_time;
    logic [MASK_W-1:0] rx_mask;
    logic [11:0]       byte_total;
  } slot_t;

  // Per-slot findings of the shared compare unit.
  typedef struct packed {
    logic active;
    logic match;
    logic stale;
    logic older;
  } scan_flags_t;

endpackage

FILE: sv/frt_scan_unit.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker scan unit
// Compares one table slot per cycle against the request: key match, age
// against the stale limit, and start time against the oldest seen so far.
// ----------------------------------------------------------------------------
module frt_scan_unit import frt_pkg::*; (
  input  slot_t       entry_i,
  input  item_t       req_i,
  input  logic [31:0] stale_time_i,
  input  logic [31:0] oldest_i,
  output scan_flags_t flags_o
);

  logic [31:0] age;

  // Elapsed time wraps modulo 2^32.
  assign age = req_i.time_now_ms - entry_i.start_time;

  always_comb begin
    flags_o.active = (entry_i.frag_total != 5'd0);
    flags_o.match  = flags_o.active && (entry_i.message_id == req_i.message_id) &&
                     (entry_i.mac == req_i.source_mac);
    flags_o.stale  = flags_o.active && (age >= stale_time_i);
    flags_o.older  = flags_o.active && (entry_i.start_time <= oldest_i);
  end

endmodule

FILE: sv/fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Slot table that follows the reassembly of fragmented messages.
// ----------------------------------------------------------------------------
// Absorb: the shared compare unit scans one slot per cycle in ST_SCAN, then
//   ST_UPDATE writes the slot and a registered done_o follows; busy until then.
// Prune: ST_PRUNE clears stale slots one per cycle; done_o follows the last slot.
// Release, a bad header or an unused command: done_o in the next cycle, and a
//   new command may be taken every cycle. The receiver cannot stall results.
// Reset clears every slot to free and sets stale_time_ms to 1000; no sweep.
module fragment_reassembly_tracker import frt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        done_o,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

  // Slot table, reset to all free. One write port, read at the scan index.
  slot_t slot_q [SLOT_COUNT];

  logic              tbl_we;
  logic [SLOT_W-1:0] tbl_idx;
  slot_t             tbl_wdata;

  logic [31:0] stale_q;

  state_e state_q, state_d;

  // Request and scan bookkeeping.
  item_t             req_q, req_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              found_q, found_d;
  logic [SLOT_W-1:0] hit_idx_q, hit_idx_d;
  slot_t             hit_q, hit_d;
  logic              free_found_q, free_found_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  logic [31:0]       oldest_q, oldest_d;
  logic [SLOT_W-1:0] oldest_idx_q, oldest_idx_d;

  logic    done_q, done_d;
  result_t result_q, result_d;

  logic        accept;
  scan_flags_t flags;

  // Update step signals.
  logic [SLOT_W-1:0]  sel_idx;
  slot_t              base;
  slot_t              upd;
  logic [MASK_W-1:0]  frag_bit;
  logic [MASK_W:0]    complete_mask;
  logic               dup;
  logic               bad_header;
  logic               release_ok;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign result_o = result_q;

  // The one compare unit, shared by the absorb search and the prune sweep.
  frt_scan_unit u_scan (
    .entry_i      (slot_q[idx_q]),
    .req_i        (req_q),
    .stale_time_i (stale_q),
    .oldest_i     (oldest_q),
    .flags_o      (flags)
  );

  assign bad_header = (item_i.fragment_count == 5'd0) ||
                      (item_i.fragment_count > MAX_FRAG_C) ||
                      (item_i.fragment_number >= item_i.fragment_count) ||
                      (item_i.payload_length > FRAG_BYTES_C);

  assign release_ok = ({1'b0, item_i.release_slot} < 5'(SLOT_COUNT));

  // The matching slot wins; else the lowest free slot; else the oldest one.
  always_comb begin
    if (found_q) begin
      sel_idx = hit_idx_q;
    end else if (free_found_q) begin
      sel_idx = free_idx_q;
    end else begin
      sel_idx = oldest_idx_q;
    end
  end

  // A fresh slot starts with an empty mask and a zero byte count.
  always_comb begin
    if (found_q) begin
      base = hit_q;
    end else begin
      base            = '0;
      base.mac        = req_q.source_mac;
      base.message_id = req_q.message_id;
      base.frag_total = req_q.fragment_count;
      base.msg_type   = req_q.message_type;
      base.start_time = req_q.time_now_ms;
    end
    frag_bit       = MASK_W'(1) << req_q.fragment_number;
    dup            = ((base.rx_mask & frag_bit) != '0);
    upd            = base;
    upd.rx_mask    = base.rx_mask | frag_bit;
    upd.byte_total = base.byte_total + 12'(req_q.payload_length);
    complete_mask  = ((MASK_W + 1)'(1) << req_q.fragment_count) - (MASK_W + 1)'(1);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.command == CMD_ABSORB && !bad_header) begin
            state_d = ST_SCAN;
          end else if (item_i.command == CMD_PRUNE) begin
            state_d = ST_PRUNE;
          end
        end
      end
      ST_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      ST_PRUNE: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and results.
  always_comb begin
    req_d        = req_q;
    idx_d        = idx_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    oldest_d     = oldest_q;
    oldest_idx_d = oldest_idx_q;
    done_d       = 1'b0;
    result_d     = result_q;
    tbl_we       = 1'b0;
    tbl_idx      = idx_q;
    tbl_wdata    = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d        = item_i;
          idx_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          oldest_d     = TIME_MAX;
          oldest_idx_d = '0;
          result_d     = '0;
          case (item_i.command)
            CMD_ABSORB: begin
              if (bad_header) begin
                done_d          = 1'b1;
                result_d.status = STAT_ERROR;
              end
            end
            CMD_PRUNE: ;
            CMD_RELEASE: begin
              tbl_we          = release_ok;
              tbl_idx         = item_i.release_slot[SLOT_W-1:0];
              done_d          = 1'b1;
              result_d.status = STAT_DONE;
            end
            default: begin
              done_d          = 1'b1;
              result_d.status = STAT_ERROR;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (flags.match && !found_q) begin
          found_d   = 1'b1;
          hit_idx_d = idx_q;
          hit_d     = slot_q[idx_q];
        end
        if (!flags.active && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        // Equal start times: the later slot takes over.
        if (flags.older) begin
          oldest_d     = slot_q[idx_q].start_time;
          oldest_idx_d = idx_q;
        end
        idx_d = idx_q + SLOT_W'(1);
      end

      ST_UPDATE: begin
        done_d  = 1'b1;
        tbl_we  = 1'b1;
        tbl_idx = sel_idx;
        result_d = '0;
        if (found_q && (hit_q.frag_total != req_q.fragment_count)) begin
          // The sender changed its fragment count: drop the slot.
          tbl_wdata       = '0;
          result_d.status = STAT_ERROR;
        end else begin
          result_d.slot_used         = 4'(sel_idx);
          result_d.stored_type       = base.msg_type;
          result_d.stored_mac        = base.mac;
          result_d.stored_message_id = base.message_id;
          if (dup) begin
            tbl_wdata                 = base;
            result_d.status           = STAT_INCOMPLETE;
            result_d.assembled_length = base.byte_total;
          end else begin
            tbl_wdata                 = upd;
            result_d.store_payload    = 1'b1;
            result_d.write_offset     = 12'(req_q.fragment_number) * 12'(FRAGMENT_BYTES);
            result_d.assembled_length = upd.byte_total;
            result_d.status = (upd.rx_mask == complete_mask[MASK_W-1:0]) ?
                              STAT_COMPLETE : STAT_INCOMPLETE;
          end
        end
      end

      ST_PRUNE: begin
        tbl_we    = flags.stale;
        tbl_wdata = '0;
        idx_d     = idx_q + SLOT_W'(1);
        if (idx_q == LAST_IDX) begin
          done_d          = 1'b1;
          result_d        = '0;
          result_d.status = STAT_DONE;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      stale_q <= 32'd1000;
      idx_q   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        stale_q <= cfg_wdata_i;
      end
      if (tbl_we) begin
        slot_q[tbl_idx] <= tbl_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    found_q      <= found_d;
    hit_idx_q    <= hit_idx_d;
    hit_q        <= hit_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    oldest_q     <= oldest_d;
    oldest_idx_q <= oldest_idx_d;
    result_q     <= result_d;
  end

  // A result transfer only follows an accepted command or work in progress.
  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start && !busy |=> !done_o)
    else $error("result strobe without a command");

  a_prune_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.command == CMD_PRUNE |=> busy && !done_o)
    else $error("prune did not start its sweep");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == STAT_ERROR || result_o.status == STAT_DONE) |->
      result_o.slot_used == 4'd0 && !result_o.store_payload &&
      result_o.assembled_length == 12'd0)
    else $error("error or maintenance result carries slot data");

  a_store_only_absorb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.store_payload |->
      result_o.status == STAT_INCOMPLETE || result_o.status == STAT_COMPLETE)
    else $error("payload store flagged outside an absorb");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> {1'b0, result_o.slot_used} < 5'(SLOT_COUNT))
    else $error("reported slot outside the table");

endmodule
